// ===== sv/hst_pkg.sv =====
// hst_pkg: shared types and constants of the handle slot table
// no dependencies
`default_nettype none

package hst_pkg;

    localparam int HANDLE_W  = 32;   // full handle as seen on the ports
    localparam int HARBOR_W  = 8;    // harbor byte in the top of a handle
    localparam int HFIELD_W  = 24;   // handle bits below the harbor byte
    localparam int CTX_W     = 16;   // context reference on the ports

    typedef logic [1:0] t_opcode;
    localparam t_opcode OP_REGISTER   = 2'd0;
    localparam t_opcode OP_RETIRE     = 2'd1;
    localparam t_opcode OP_LOOKUP     = 2'd2;
    localparam t_opcode OP_RETIRE_ALL = 2'd3;

    typedef logic [1:0] t_status;
    localparam t_status STS_OK      = 2'd0;
    localparam t_status STS_NOMATCH = 2'd1;
    localparam t_status STS_FULL    = 2'd2;

    // control of the slot-used bit array
    typedef struct packed {
        logic set;
        logic clr;
        logic clear_all;
    } t_used_ctl;

    // control of the slot payload memory
    typedef struct packed {
        logic wr;
        logic rd;
    } t_mem_ctl;

endpackage

`default_nettype wire

// ===== sv/handle_slot_table.sv =====
// handle_slot_table: direct-mapped handle allocator, top level and sequencer
// depends on hst_pkg, hst_used_bits, hst_slot_mem, hst_scan_step
//
//  channel   | ports                                          | handshake
//  ----------+------------------------------------------------+---------------------------
//  command   | start, i_opcode, i_handle_in, i_context_ref    | beat when start && !busy
//  result    | o_done, o_handle_out, o_context_out, o_status  | one-cycle strobe o_done
//  config    | i_cfg_valid, o_cfg_ready, i_cfg_data           | beat when valid && ready
//
//  lookup and retire: the beat issues the memory read, ST_CHECK compares, and the strobe is registered from ST_CHECK
//  register: k slots are probed, k = slots probed (1 .. SLOT_COUNT), one probe
//    of the used flags per cycle through the scan step unit; the strobe is registered from the last probe
//  retire all: strobe in the cycle after the beat, the used flags all clear at once
//  reset clears the used flags and the harbor byte and sets the handle counter to one at once, no sweep of the memory
//  the result side cannot stall; a new command is taken in the cycle its predecessor strobes
`default_nettype none

module handle_slot_table
    import hst_pkg::*;
#(
    parameter int SLOT_COUNT   = 256,
    parameter int HANDLE_BITS  = 24,
    parameter int CONTEXT_BITS = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // command
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [1:0]          i_opcode,
    input  wire logic [HANDLE_W-1:0] i_handle_in,
    input  wire logic [CTX_W-1:0]    i_context_ref,
    // result
    output logic                     o_done,
    output logic [HANDLE_W-1:0]      o_handle_out,
    output logic [CTX_W-1:0]         o_context_out,
    output logic [1:0]               o_status,
    // harbor id register
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [HARBOR_W-1:0] i_cfg_data
);

    localparam int IW = $clog2(SLOT_COUNT);
    // stored context width: the port carries at most CTX_W bits
    localparam int CW = (CONTEXT_BITS < CTX_W) ? CONTEXT_BITS : CTX_W;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_CHECK = 2'd2;

    // control state
    logic [1:0]             r_state,  n_state;
    logic [HANDLE_BITS-1:0] r_next,   n_next;
    logic [HARBOR_W-1:0]    r_harbor;
    logic                   r_done,   n_done;

    // working and result payload
    logic [HANDLE_BITS-1:0] r_h,      n_h;
    logic [IW-1:0]          r_cnt,    n_cnt;
    logic [CW-1:0]          r_ctx,    n_ctx;
    logic [HANDLE_W-1:0]    r_hin,    n_hin;
    t_opcode                r_op,     n_op;
    logic [HANDLE_W-1:0]    r_hout,   n_hout;
    logic [CTX_W-1:0]       r_cout,   n_cout;
    t_status                r_status, n_status;

    t_used_ctl              used_ctl;
    t_mem_ctl               mem_ctl;
    logic [IW-1:0]          used_addr;
    logic                   used_bit;
    logic [HANDLE_W-1:0]    rd_handle;
    logic [CW-1:0]          rd_ctx;
    logic [HANDLE_BITS-1:0] step_next;
    logic                   step_free;
    logic                   step_last;
    logic                   accept;
    logic [IW-1:0]          scan_idx;
    logic [HANDLE_W-1:0]    scan_full;

    assign busy        = (r_state != ST_IDLE);
    assign accept      = start && !busy;
    assign o_cfg_ready = 1'b1;

    // slot of a handle is its low bits
    assign scan_idx  = IW'(r_h);
    assign scan_full = {r_harbor, HFIELD_W'(r_h)};
    assign used_addr = (r_state == ST_CHECK) ? IW'(r_hin) : scan_idx;

    hst_used_bits #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_used (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (used_ctl),
        .i_addr  (used_addr),
        .o_used  (used_bit)
    );

    hst_slot_mem #(
        .SLOT_COUNT (SLOT_COUNT),
        .CW         (CW)
    ) u_mem (
        .i_clk       (i_clk),
        .i_ctl       (mem_ctl),
        .i_wr_addr   (scan_idx),
        .i_wr_handle (scan_full),
        .i_wr_ctx    (r_ctx),
        .i_rd_addr   (IW'(i_handle_in)),
        .o_rd_handle (rd_handle),
        .o_rd_ctx    (rd_ctx)
    );

    hst_scan_step #(
        .SLOT_COUNT  (SLOT_COUNT),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_step (
        .i_h      (r_h),
        .i_used   (used_bit),
        .i_cnt    (r_cnt),
        .o_h_next (step_next),
        .o_free   (step_free),
        .o_last   (step_last)
    );

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_next   = r_next;
        n_done   = 1'b0;
        n_h      = r_h;
        n_cnt    = r_cnt;
        n_ctx    = r_ctx;
        n_hin    = r_hin;
        n_op     = r_op;
        n_hout   = r_hout;
        n_cout   = r_cout;
        n_status = r_status;
        used_ctl = '0;
        mem_ctl  = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    unique case (i_opcode)
                        OP_REGISTER: begin
                            // counter is never zero, scan starts right at it
                            n_h     = r_next;
                            n_cnt   = '0;
                            n_ctx   = CW'(i_context_ref);
                            n_state = ST_SCAN;
                        end
                        OP_RETIRE, OP_LOOKUP: begin
                            mem_ctl.rd = 1'b1;
                            n_hin      = i_handle_in;
                            n_op       = i_opcode;
                            n_state    = ST_CHECK;
                        end
                        OP_RETIRE_ALL: begin
                            used_ctl.clear_all = 1'b1;
                            n_done   = 1'b1;
                            n_hout   = '0;
                            n_cout   = '0;
                            n_status = STS_OK;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                priority if (step_free) begin
                    // free slot: claim it and issue the handle
                    mem_ctl.wr   = 1'b1;
                    used_ctl.set = 1'b1;
                    n_next   = step_next;
                    n_done   = 1'b1;
                    n_hout   = scan_full;
                    n_cout   = '0;
                    n_status = STS_OK;
                    n_state  = ST_IDLE;
                end else if (step_last) begin
                    // every slot probed: table full, nothing changes
                    n_done   = 1'b1;
                    n_hout   = '0;
                    n_cout   = '0;
                    n_status = STS_FULL;
                    n_state  = ST_IDLE;
                end else begin
                    n_h   = step_next;
                    n_cnt = r_cnt + IW'(1);
                end
            end
            ST_CHECK: begin
                n_done  = 1'b1;
                n_hout  = '0;
                n_state = ST_IDLE;
                // all 32 bits must match, harbor byte included
                if (used_bit && (rd_handle == r_hin)) begin
                    n_cout   = CTX_W'(rd_ctx);
                    n_status = STS_OK;
                    if (r_op == OP_RETIRE) begin
                        used_ctl.clr = 1'b1;
                    end
                end else begin
                    n_cout   = '0;
                    n_status = STS_NOMATCH;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_next   <= HANDLE_BITS'(1);
            r_harbor <= '0;
            r_done   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_next  <= n_next;
            r_done  <= n_done;
            if (i_cfg_valid && o_cfg_ready) begin
                r_harbor <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_h      <= n_h;
        r_cnt    <= n_cnt;
        r_ctx    <= n_ctx;
        r_hin    <= n_hin;
        r_op     <= n_op;
        r_hout   <= n_hout;
        r_cout   <= n_cout;
        r_status <= n_status;
    end

    assign o_done        = r_done;
    assign o_handle_out  = r_hout;
    assign o_context_out = r_cout;
    assign o_status      = r_status;

`ifndef SYNTHESIS
    // handle counter never rests on the reserved zero
    a_next_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next != '0)
        else $error("handle counter holds zero");

    // a lookup or retire beat goes to the compare state
    a_check_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_opcode == OP_LOOKUP || i_opcode == OP_RETIRE))
        |=> (r_state == ST_CHECK))
        else $error("lookup or retire did not enter compare");

    // compare always ends in exactly one result beat
    a_check_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CHECK) |=> (o_done && r_state == ST_IDLE))
        else $error("compare state gave no result");

    // an issued handle never carries the reserved zero
    a_issued_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == STS_OK && o_handle_out != '0)
        |-> (o_handle_out[HFIELD_W-1:0] != '0))
        else $error("issued handle has zero handle bits");
`endif

endmodule

`default_nettype wire

// ===== sv/hst_used_bits.sv =====
// hst_used_bits: per-slot used flags in flip-flops, cleared at once
// depends on hst_pkg
`default_nettype none

module hst_used_bits
    import hst_pkg::*;
#(
    parameter int SLOT_COUNT = 256
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire t_used_ctl                     i_ctl,
    input  wire logic [$clog2(SLOT_COUNT)-1:0] i_addr,
    output logic                               o_used
);

    logic [SLOT_COUNT-1:0] r_used;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (i_ctl.clear_all) begin
            r_used <= '0;
        end else if (i_ctl.set) begin
            r_used[i_addr] <= 1'b1;
        end else if (i_ctl.clr) begin
            r_used[i_addr] <= 1'b0;
        end
    end

    assign o_used = r_used[i_addr];

endmodule

`default_nettype wire

// ===== sv/hst_slot_mem.sv =====
// hst_slot_mem: stored handle and context of each slot, registered read
// depends on hst_pkg
`default_nettype none

module hst_slot_mem
    import hst_pkg::*;
#(
    parameter int SLOT_COUNT = 256,
    parameter int CW         = 16
) (
    input  wire logic                          i_clk,
    input  wire t_mem_ctl                      i_ctl,
    input  wire logic [$clog2(SLOT_COUNT)-1:0] i_wr_addr,
    input  wire logic [HANDLE_W-1:0]           i_wr_handle,
    input  wire logic [CW-1:0]                 i_wr_ctx,
    input  wire logic [$clog2(SLOT_COUNT)-1:0] i_rd_addr,
    output logic      [HANDLE_W-1:0]           o_rd_handle,
    output logic      [CW-1:0]                 o_rd_ctx
);

    logic [HANDLE_W-1:0] r_handle_mem [SLOT_COUNT];
    logic [CW-1:0]       r_ctx_mem    [SLOT_COUNT];

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_handle_mem[i_wr_addr] <= i_wr_handle;
            r_ctx_mem[i_wr_addr]    <= i_wr_ctx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd) begin
            o_rd_handle <= r_handle_mem[i_rd_addr];
            o_rd_ctx    <= r_ctx_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/hst_scan_step.sv =====
// hst_scan_step: one probe of the free-slot scan, handle advance with wrap
// depends on hst_pkg
`default_nettype none

module hst_scan_step
    import hst_pkg::*;
#(
    parameter int SLOT_COUNT  = 256,
    parameter int HANDLE_BITS = 24
) (
    input  wire logic [HANDLE_BITS-1:0]        i_h,
    input  wire logic                          i_used,
    input  wire logic [$clog2(SLOT_COUNT)-1:0] i_cnt,
    output logic      [HANDLE_BITS-1:0]        o_h_next,
    output logic                               o_free,
    output logic                               o_last
);

    localparam int IW = $clog2(SLOT_COUNT);

    logic [HANDLE_BITS-1:0] inc;

    // handle zero is reserved, so the counter wraps to one
    assign inc      = i_h + HANDLE_BITS'(1);
    assign o_h_next = (inc == '0) ? HANDLE_BITS'(1) : inc;
    assign o_free   = !i_used;
    assign o_last   = (i_cnt == IW'(SLOT_COUNT - 1));

endmodule

`default_nettype wire
